>>> rtl/truetype_glyph_outline_decoder_defines.svh
// assertion macros shared by the glyph decoder modules
`ifndef TRUETYPE_GLYPH_OUTLINE_DECODER_DEFINES_SVH
`define TRUETYPE_GLYPH_OUTLINE_DECODER_DEFINES_SVH

// same-cycle implication
`define TGOD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glyph decoder assertion failed");

// next-cycle implication
`define TGOD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glyph decoder assertion failed");

`endif

>>> rtl/tgod_pkg.sv
// types, codes and defaults for the glyph outline decoder
`default_nettype none
package tgod_pkg;

	localparam int MaxPointsDefault   = 64;
	localparam int MaxContoursDefault = 16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_COMPOSITE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_HOLD,
		OP_HDR_WORD,
		OP_HDR_CNT,
		OP_HDR_END,
		OP_EP_STORE,
		OP_EP_LAST,
		OP_INSLEN,
		OP_INSDEC,
		OP_FLAG_WR,
		OP_REP_LOAD,
		OP_REP_COPY,
		OP_AXIS_START,
		OP_FETCH,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		DK_ZERO,
		DK_SHORT,
		DK_WORD,
		DK_FAIL
	} delta_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               on_outline;
		logic               contour_end;
		logic               last_point;
		logic [1:0]         status;
	} out_item_t;

	typedef struct packed {
		logic        take;
		op_t         op;
		delta_kind_t kind;
		logic        axis;
		status_t     fail_code;
		logic        fail;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic cd_zero;
		logic cd_one;
		logic cd_ge9;
		logic cd_le1;
		logic word_neg;
		logic word_gt_mc;
		logic word_zero;
		logic word_ge_mp;
		logic ct_zero;
		logic ep_last;
		logic rep;
		logic rep_end;
		logic cur_ge_tot;
		logic f_short;
		logic f_same;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/tgod_dp.sv
// datapath: byte latch, counters, stores, running sum and result register
`default_nettype none
`include "truetype_glyph_outline_decoder_defines.svh"
module tgod_dp
	import tgod_pkg::*;
#(
	parameter int MAX_POINTS   = MaxPointsDefault,
	parameter int MAX_CONTOURS = MaxContoursDefault
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire cmd_t      cmd,
	output sts_t           sts,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int PIW = $clog2(MAX_POINTS);
	localparam int CCW = $clog2(MAX_CONTOURS + 1);
	localparam int CIW = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

	logic [7:0]     byte_q;
	logic           first_q;
	logic [7:0]     high_q;
	logic [15:0]    cd_q;
	logic [CCW-1:0] ct_q;
	logic [CCW-1:0] cc_q;
	logic [PCW-1:0] tot_q;
	logic [PCW-1:0] cur_q;
	logic           rep_q;
	logic [7:0]     cnt_q;
	logic [5:0]     last_flag_q;
	logic [15:0]    sum_q;

	logic [15:0] cend_mem [MAX_CONTOURS];
	logic [5:0]  flag_mem [MAX_POINTS];
	logic [15:0] x_mem    [MAX_POINTS];
	logic [5:0]  flag_rd_q;
	logic [15:0] x_rd_q;
	logic [15:0] cend_rd_q;

	logic            out_valid_q;
	out_item_t       out_q;

	logic [15:0]     word;
	logic [15:0]     delta;
	logic [15:0]     sum_new;
	logic            out_free;
	logic            emit;
	logic            is_last;
	logic            match;
	logic [PIW-1:0]  pidx;
	logic [CIW-1:0]  cidx;

	assign word     = {high_q, byte_q};
	assign out_free = !out_valid_q || out_ready;
	assign pidx     = cur_q[PIW-1:0];
	assign cidx     = cc_q[CIW-1:0];

	always_comb begin
		case (cmd.kind)
			DK_SHORT: delta = flag_rd_q[4 + cmd.axis] ? {8'h00, byte_q}
			                                          : 16'h0000 - {8'h00, byte_q};
			DK_WORD:  delta = word;
			default:  delta = 16'h0000;
		endcase
	end
	assign sum_new = sum_q + delta;
	assign is_last = ({1'b0, cur_q} + (PCW+1)'(1)) >= {1'b0, tot_q};
	assign match   = (cc_q < ct_q) && ({{(16-PCW){1'b0}}, cur_q} == cend_rd_q);
	assign emit    = cmd.fail || (cmd.op == OP_FINISH && cmd.axis);

	always_comb begin
		sts.first      = first_q;
		sts.cd_zero    = cd_q == 16'd0;
		sts.cd_one     = cd_q == 16'd1;
		sts.cd_ge9     = cd_q >= 16'd9;
		sts.cd_le1     = cd_q <= 16'd1;
		sts.word_neg   = word[15];
		sts.word_gt_mc = word > 16'(MAX_CONTOURS);
		sts.word_zero  = word == 16'd0;
		sts.word_ge_mp = word >= 16'(MAX_POINTS);
		sts.ct_zero    = ct_q == '0;
		sts.ep_last    = ({1'b0, cc_q} + (CCW+1)'(1)) >= {1'b0, ct_q};
		sts.rep        = rep_q;
		sts.rep_end    = (cnt_q == 8'd0) || (cur_q >= tot_q);
		sts.cur_ge_tot = cur_q >= tot_q;
		sts.f_short    = flag_rd_q[1 + cmd.axis];
		sts.f_same     = flag_rd_q[4 + cmd.axis];
		sts.out_free   = out_free;
	end

	// stores and their registered read ports
	always_ff @(posedge clk) begin
		if (cmd.op == OP_EP_STORE || cmd.op == OP_EP_LAST)
			cend_mem[cidx] <= word;
		if (cmd.op == OP_FLAG_WR)
			flag_mem[pidx] <= byte_q[5:0];
		else if (cmd.op == OP_REP_COPY)
			flag_mem[pidx] <= last_flag_q;
		if (cmd.op == OP_FINISH && !cmd.axis)
			x_mem[pidx] <= sum_new;
		if (cmd.op == OP_FETCH) begin
			flag_rd_q <= flag_mem[pidx];
			x_rd_q    <= x_mem[pidx];
			cend_rd_q <= cend_mem[cidx];
		end
		if (cmd.take)
			byte_q <= in_data.data_byte;
		if (cmd.op == OP_FLAG_WR)
			last_flag_q <= byte_q[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			high_q  <= 8'h00;
			cd_q    <= 16'd0;
			ct_q    <= '0;
			cc_q    <= '0;
			tot_q   <= '0;
			cur_q   <= '0;
			rep_q   <= 1'b0;
			cnt_q   <= 8'h00;
			sum_q   <= 16'd0;
		end else begin
			if (cmd.take)
				first_q <= in_data.first_byte;
			case (cmd.op)
				OP_START: begin
					high_q <= byte_q;
					cd_q   <= 16'd1;
					ct_q   <= '0;
					cc_q   <= '0;
					tot_q  <= '0;
					cur_q  <= '0;
					rep_q  <= 1'b0;
					sum_q  <= 16'd0;
				end
				OP_HOLD: begin
					high_q <= byte_q;
					cd_q   <= 16'd1;
				end
				OP_HDR_WORD: begin
					ct_q <= word[CCW-1:0];
					cd_q <= cd_q + 16'd1;
				end
				OP_HDR_CNT: cd_q <= cd_q + 16'd1;
				OP_HDR_END: begin
					cd_q <= 16'd0;
					cc_q <= '0;
				end
				OP_EP_STORE: begin
					cc_q <= cc_q + CCW'(1);
					cd_q <= 16'd0;
				end
				OP_EP_LAST: begin
					cc_q  <= '0;
					cd_q  <= 16'd0;
					tot_q <= word[PCW-1:0] + PCW'(1);
				end
				OP_INSLEN: begin
					cd_q  <= word;
					cur_q <= '0;
					rep_q <= 1'b0;
				end
				OP_INSDEC: cd_q <= cd_q - 16'd1;
				OP_FLAG_WR: begin
					cur_q <= cur_q + PCW'(1);
					rep_q <= byte_q[3];
				end
				OP_REP_LOAD: begin
					cnt_q <= byte_q;
					rep_q <= 1'b0;
				end
				OP_REP_COPY: begin
					cur_q <= cur_q + PCW'(1);
					cnt_q <= cnt_q - 8'd1;
				end
				OP_AXIS_START: begin
					cur_q <= '0;
					sum_q <= 16'd0;
					cc_q  <= '0;
					cd_q  <= 16'd0;
				end
				OP_FINISH: begin
					sum_q <= sum_new;
					cur_q <= cur_q + PCW'(1);
					cd_q  <= 16'd0;
					if (cmd.axis && match)
						cc_q <= cc_q + CCW'(1);
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= emit || (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.fail) begin
				out_q.point_x     <= 16'sd0;
				out_q.point_y     <= 16'sd0;
				out_q.on_outline  <= 1'b0;
				out_q.contour_end <= 1'b0;
				out_q.last_point  <= 1'b1;
				out_q.status      <= cmd.fail_code;
			end else begin
				out_q.point_x     <= signed'(x_rd_q);
				out_q.point_y     <= signed'(sum_new);
				out_q.on_outline  <= flag_rd_q[0];
				out_q.contour_end <= is_last || match;
				out_q.last_point  <= is_last;
				out_q.status      <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TGOD_ASSERT_IMP(a_cursor_bound, clk, arst_n, 1'b1, cur_q <= tot_q)
	`TGOD_ASSERT_IMP(a_contour_bound, clk, arst_n, 1'b1, cc_q <= ct_q)
	`TGOD_ASSERT_NXT(a_fail_last, clk, arst_n, cmd.fail, out_valid_q && out_q.last_point)

endmodule
`default_nettype wire

>>> rtl/tgod_ctrl.sv
// controller: parse phase and step sequencing
`default_nettype none
`include "truetype_glyph_outline_decoder_defines.svh"
module tgod_ctrl
	import tgod_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IN,
		S_PROC,
		S_REPEAT,
		S_FLAGCHK,
		S_FETCH,
		S_EVAL
	} state_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ENDPTS,
		PH_INSLEN,
		PH_INSSKIP,
		PH_FLAGS,
		PH_XCOORD,
		PH_YCOORD,
		PH_IDLE
	} phase_t;

	state_t state_q, state_n;
	phase_t phase_q, phase_n;

	assign in_ready = state_q == S_IN;

	always_comb begin
		cmd.take      = in_valid && (state_q == S_IN);
		cmd.op        = OP_NONE;
		cmd.kind      = DK_ZERO;
		cmd.axis      = phase_q == PH_YCOORD;
		cmd.fail_code = ST_OK;
		cmd.fail      = 1'b0;
		state_n       = state_q;
		phase_n       = phase_q;
		case (state_q)
			S_IN: begin
				if (in_valid)
					state_n = S_PROC;
			end
			S_PROC: begin
				if (sts.out_free) begin
					state_n = S_IN;
					if (sts.first) begin
						cmd.op  = OP_START;
						phase_n = PH_HEADER;
					end else begin
						case (phase_q)
							PH_HEADER: begin
								if (sts.cd_zero) begin
									cmd.op = OP_HOLD;
								end else if (sts.cd_one) begin
									if (sts.word_neg) begin
										cmd.fail      = 1'b1;
										cmd.fail_code = ST_COMPOSITE;
										phase_n       = PH_IDLE;
									end else if (sts.word_gt_mc) begin
										cmd.fail      = 1'b1;
										cmd.fail_code = ST_RANGE;
										phase_n       = PH_IDLE;
									end else begin
										cmd.op = OP_HDR_WORD;
									end
								end else if (sts.cd_ge9) begin
									cmd.op  = OP_HDR_END;
									phase_n = sts.ct_zero ? PH_IDLE : PH_ENDPTS;
								end else begin
									cmd.op = OP_HDR_CNT;
								end
							end
							PH_ENDPTS: begin
								if (sts.cd_zero) begin
									cmd.op = OP_HOLD;
								end else if (!sts.ep_last) begin
									cmd.op = OP_EP_STORE;
								end else if (sts.word_ge_mp) begin
									cmd.fail      = 1'b1;
									cmd.fail_code = ST_RANGE;
									phase_n       = PH_IDLE;
								end else begin
									cmd.op  = OP_EP_LAST;
									phase_n = PH_INSLEN;
								end
							end
							PH_INSLEN: begin
								if (sts.cd_zero) begin
									cmd.op = OP_HOLD;
								end else begin
									cmd.op  = OP_INSLEN;
									phase_n = sts.word_zero ? PH_FLAGS : PH_INSSKIP;
								end
							end
							PH_INSSKIP: begin
								cmd.op = OP_INSDEC;
								if (sts.cd_le1)
									phase_n = PH_FLAGS;
							end
							PH_FLAGS: begin
								if (sts.rep) begin
									cmd.op  = OP_REP_LOAD;
									state_n = S_REPEAT;
								end else begin
									cmd.op  = OP_FLAG_WR;
									state_n = S_FLAGCHK;
								end
							end
							PH_XCOORD, PH_YCOORD: begin
								if (sts.f_short) begin
									cmd.op   = OP_FINISH;
									cmd.kind = DK_SHORT;
									state_n  = S_FETCH;
								end else if (sts.cd_zero) begin
									cmd.op = OP_HOLD;
								end else begin
									cmd.op   = OP_FINISH;
									cmd.kind = DK_WORD;
									state_n  = S_FETCH;
								end
							end
							default: ;
						endcase
					end
				end
			end
			S_REPEAT: begin
				if (sts.rep_end)
					state_n = S_FLAGCHK;
				else
					cmd.op = OP_REP_COPY;
			end
			S_FLAGCHK: begin
				if (sts.cur_ge_tot && !sts.rep) begin
					cmd.op  = OP_AXIS_START;
					phase_n = PH_XCOORD;
					state_n = S_FETCH;
				end else begin
					state_n = S_IN;
				end
			end
			S_FETCH: begin
				cmd.op  = OP_FETCH;
				state_n = S_EVAL;
			end
			S_EVAL: begin
				// points with no coordinate byte finish here, one per pass
				if (sts.out_free) begin
					if (sts.cur_ge_tot) begin
						if (phase_q == PH_XCOORD) begin
							cmd.op  = OP_AXIS_START;
							phase_n = PH_YCOORD;
							state_n = S_FETCH;
						end else begin
							phase_n = PH_IDLE;
							state_n = S_IN;
						end
					end else if (sts.f_short || !sts.f_same) begin
						state_n = S_IN;
					end else begin
						cmd.op   = OP_FINISH;
						cmd.kind = DK_ZERO;
						state_n  = S_FETCH;
					end
				end
			end
			default: state_n = S_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			phase_q <= PH_HEADER;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
		end
	end

	`TGOD_ASSERT_NXT(a_take_proc, clk, arst_n, cmd.take, state_q == S_PROC)
	`TGOD_ASSERT_NXT(a_fetch_eval, clk, arst_n, state_q == S_FETCH, state_q == S_EVAL)
	`TGOD_ASSERT_NXT(a_stall_hold, clk, arst_n, state_q == S_PROC && !sts.out_free,
		state_q == S_PROC)

endmodule
`default_nettype wire

>>> rtl/truetype_glyph_outline_decoder.sv
// top level of the simple glyph outline decoder
`default_nettype none
// Takes one byte of a simple glyph record per accepted word and returns one
// word per outline point with absolute x and y, on-curve, contour-end and
// last-point marks, or a single error word for composite glyphs and counts
// beyond MAX_CONTOURS or MAX_POINTS. Each byte passes through the controller
// as an accept, then one step of the parse; a flag byte is followed by the
// end-of-flags check. A byte that ends a point is followed by the flag and
// x-store read of the next point, as is every following point that carries
// no coordinate byte and the switch from x to y. A flag repeat count byte
// copies the flags one at a time, since the flag store has one write port.
// Results wait in a single output register; while it is full and not being
// taken, every parse step and the no-byte point loop wait.
module truetype_glyph_outline_decoder
	import tgod_pkg::*;
#(
	parameter int MAX_POINTS   = MaxPointsDefault,
	parameter int MAX_CONTOURS = MaxContoursDefault
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	cmd_t cmd;
	sts_t sts;

	tgod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgod_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CONTOURS (MAX_CONTOURS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> test/truetype_glyph_outline_decoder_tb.sv
// testbench for the glyph outline decoder: glyph byte streams against a local predictor
`default_nettype none
module truetype_glyph_outline_decoder_tb;
	import tgod_pkg::*;

	localparam int MaxPts = 64;
	localparam int MaxCnt = 16;
	localparam int WatchLimit = 20000;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_ENDPTS = 3'd1;
	localparam logic [2:0] PH_INSLEN = 3'd2;
	localparam logic [2:0] PH_INSSKIP = 3'd3;
	localparam logic [2:0] PH_FLAGS = 3'd4;
	localparam logic [2:0] PH_XCOORD = 3'd5;
	localparam logic [2:0] PH_YCOORD = 3'd6;
	localparam logic [2:0] PH_IDLE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	truetype_glyph_outline_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [2:0] ph;
	int unsigned cd;
	int unsigned ctot, ccur, ptot, pcur;
	logic [15:0] ep_mem [MaxCnt];
	logic [5:0] flag_mem [MaxPts];
	logic [15:0] xmem [MaxPts];
	logic rep_pend;
	logic [15:0] rsum;
	logic [7:0] hold;

	in_item_t pending_bytes [$];
	out_item_t expected_points [$];
	int errors = 0;
	bit stim_done = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic push_point(input logic [15:0] x, input logic [15:0] y,
			input logic oc, input logic ce, input logic lp, input logic [1:0] st);
		out_item_t r;
		r.point_x = x;
		r.point_y = y;
		r.on_outline = oc;
		r.contour_end = ce;
		r.last_point = lp;
		r.status = st;
		expected_points.push_back(r);
	endtask

	task automatic glyph_error(input status_t st);
		push_point(16'd0, 16'd0, 1'b0, 1'b0, 1'b1, st);
		ph = PH_IDLE;
	endtask

	task automatic restart_record();
		ph = PH_HEADER;
		cd = 0; ctot = 0; ccur = 0; ptot = 0; pcur = 0;
		rep_pend = 0; rsum = 0; hold = 0;
	endtask

	task automatic finish_pt(input logic [15:0] d);
		int unsigned i;
		logic lp, ce;
		i = pcur % MaxPts;
		rsum = rsum + d;
		if (ph == PH_XCOORD) begin
			xmem[i] = rsum;
		end else begin
			lp = (pcur + 1 >= ptot);
			ce = lp;
			if (ccur < ctot && pcur == ep_mem[ccur % MaxCnt]) begin
				ce = 1'b1;
				ccur++;
			end
			push_point(xmem[i], rsum, flag_mem[i][0], ce, lp, ST_OK);
		end
		pcur++;
		cd = 0;
	endtask

	// walk over axis ends and points that take no byte
	task automatic settle_points();
		int ax;
		logic [5:0] f;
		forever begin
			if (ph != PH_XCOORD && ph != PH_YCOORD) return;
			if (pcur >= ptot) begin
				if (ph == PH_XCOORD) begin
					ph = PH_YCOORD;
					pcur = 0; rsum = 0; ccur = 0; cd = 0;
					continue;
				end
				ph = PH_IDLE;
				return;
			end
			ax = (ph == PH_YCOORD);
			f = flag_mem[pcur % MaxPts];
			if (f[1 + ax] || !f[4 + ax]) return;
			finish_pt(16'd0);
		end
	endtask

	task automatic predict_byte(input in_item_t it);
		logic [7:0] b;
		logic [15:0] w;
		int unsigned cnt, ax;
		logic [5:0] f, prev;
		b = it.data_byte;
		if (it.first_byte) restart_record();
		case (ph)
			PH_HEADER: begin
				if (cd == 0) begin
					hold = b;
				end else if (cd == 1) begin
					w = {hold, b};
					if (w[15]) begin
						glyph_error(ST_COMPOSITE);
						return;
					end
					if (w > MaxCnt) begin
						glyph_error(ST_RANGE);
						return;
					end
					ctot = w;
				end
				if (cd >= 9) begin
					cd = 0;
					ccur = 0;
					ph = (ctot == 0) ? PH_IDLE : PH_ENDPTS;
				end else begin
					cd++;
				end
			end
			PH_ENDPTS: begin
				if (cd == 0) begin
					hold = b;
					cd = 1;
				end else begin
					cd = 0;
					w = {hold, b};
					ep_mem[ccur % MaxCnt] = w;
					ccur++;
					if (ccur >= ctot) begin
						if (w >= MaxPts) begin
							glyph_error(ST_RANGE);
							return;
						end
						ptot = w + 1;
						ccur = 0;
						ph = PH_INSLEN;
					end
				end
			end
			PH_INSLEN: begin
				if (cd == 0) begin
					hold = b;
					cd = 1;
				end else begin
					cd = {hold, b};
					pcur = 0;
					rep_pend = 0;
					ph = (cd == 0) ? PH_FLAGS : PH_INSSKIP;
				end
			end
			PH_INSSKIP: begin
				if (cd > 0) cd--;
				if (cd == 0) ph = PH_FLAGS;
			end
			PH_FLAGS: begin
				if (rep_pend) begin
					cnt = b;
					prev = flag_mem[(pcur + MaxPts - 1) % MaxPts];
					while (cnt > 0 && pcur < ptot) begin
						flag_mem[pcur % MaxPts] = prev;
						pcur++;
						cnt--;
					end
					rep_pend = 0;
				end else begin
					flag_mem[pcur % MaxPts] = b[5:0];
					pcur++;
					rep_pend = b[3];
				end
				if (pcur >= ptot && !rep_pend) begin
					ph = PH_XCOORD;
					pcur = 0; rsum = 0; cd = 0;
					settle_points();
				end
			end
			PH_XCOORD, PH_YCOORD: begin
				ax = (ph == PH_YCOORD);
				f = flag_mem[pcur % MaxPts];
				if (f[1 + ax]) begin
					finish_pt(f[4 + ax] ? {8'd0, b} : 16'd0 - {8'd0, b});
					settle_points();
				end else if (cd == 0) begin
					hold = b;
					cd = 1;
				end else begin
					finish_pt({hold, b});
					settle_points();
				end
			end
			default: ;
		endcase
	endtask

	// stimulus helpers
	task automatic put_byte(input logic [7:0] b, input logic fb);
		in_item_t it;
		it.data_byte = b;
		it.first_byte = fb;
		pending_bytes.push_back(it);
	endtask

	task automatic put_word(input logic [15:0] w);
		put_byte(w[15:8], 1'b0);
		put_byte(w[7:0], 1'b0);
	endtask

	// a simple glyph with random content, well-formed unless wild is set
	task automatic put_glyph(input int nc, input int np, input bit wild);
		int e, n, k, r;
		logic [7:0] f;
		logic [5:0] fl [$];
		put_byte(8'(nc >> 8), 1'b1);
		put_byte(8'(nc), 1'b0);
		for (int i = 0; i < 8; i++) put_byte(8'($urandom), 1'b0);
		e = -1;
		for (int i = 0; i < nc; i++) begin
			if (i == nc - 1) e = np - 1;
			else if (e < np - 2 - (nc - 2 - i)) e = $urandom_range(e + 1, np - 2 - (nc - 2 - i));
			if (wild && $urandom_range(0, 5) == 0) put_word(16'($urandom_range(0, 70)));
			else put_word(16'(e));
		end
		n = $urandom_range(0, 3);
		put_word(16'(n));
		for (int i = 0; i < n; i++) put_byte(8'($urandom), 1'b0);
		k = 0;
		while (k < np) begin
			f = 8'($urandom);
			if ($urandom_range(0, 2) != 0) f[3] = 1'b0;
			put_byte(f, 1'b0);
			fl.push_back(f[5:0]);
			k++;
			if (f[3]) begin
				r = $urandom_range(0, 6);
				if (wild && $urandom_range(0, 3) == 0) r = $urandom_range(0, 255);
				put_byte(8'(r), 1'b0);
				for (int j = 0; j < r && k < np; j++) begin
					fl.push_back(f[5:0]);
					k++;
				end
			end
		end
		for (int ax = 0; ax < 2; ax++)
			for (int i = 0; i < np; i++) begin
				if (fl[i][1 + ax]) put_byte(8'($urandom), 1'b0);
				else if (!fl[i][4 + ax]) put_word(16'($urandom));
			end
		if (wild) for (int i = 0; i < $urandom_range(0, 3); i++) put_byte(8'($urandom), 1'b0);
	endtask

	// driver: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_byte(in_data);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_data <= pending_bytes.pop_front();
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	int cyc = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == 300) hold_cnt <= 400;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
		if (hold_cnt > 1 || cyc == 300) out_ready <= 1'b0;
		else if ((cyc / 64) % 3 == 0) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// monitor
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report($sformatf("unexpected word %h", out_data));
				end else begin
					out_item_t e;
					e = expected_points.pop_front();
					if (out_data.point_x !== e.point_x)
						report($sformatf("point_x %h want %h", out_data.point_x, e.point_x));
					if (out_data.point_y !== e.point_y)
						report($sformatf("point_y %h want %h", out_data.point_y, e.point_y));
					if (out_data.on_outline !== e.on_outline)
						report($sformatf("on_outline %b want %b", out_data.on_outline,
							e.on_outline));
					if (out_data.contour_end !== e.contour_end)
						report($sformatf("contour_end %b want %b", out_data.contour_end,
							e.contour_end));
					if (out_data.last_point !== e.last_point)
						report($sformatf("last_point %b want %b", out_data.last_point,
							e.last_point));
					if (out_data.status !== e.status)
						report($sformatf("status %d want %d", out_data.status, e.status));
				end
			end
			if (idle_cycles >= WatchLimit) begin
				$display("watchdog expired");
				$display("** truetype_glyph_outline_decoder: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int np, nc;
		restart_record();
		// directed: byte without mark right after reset, composite, too many contours
		put_byte(8'h00, 1'b0); put_byte(8'h01, 1'b0);
		for (int i = 0; i < 8; i++) put_byte(8'hFF, 1'b0);
		put_word(16'd1); put_word(16'd0);
		put_byte(8'h37, 1'b0); put_byte(8'hFF, 1'b0); put_byte(8'h80, 1'b0);
		put_byte(8'h80, 1'b1); put_byte(8'h00, 1'b0); put_byte(8'h55, 1'b0);
		put_byte(8'h00, 1'b1); put_byte(8'h11, 1'b0);
		// zero contours then trailing bytes
		put_byte(8'h00, 1'b1); put_byte(8'h00, 1'b0);
		for (int i = 0; i < 10; i++) put_byte(8'hA5, 1'b0);
		// too many points
		put_byte(8'h00, 1'b1); put_byte(8'h01, 1'b0);
		for (int i = 0; i < 8; i++) put_byte(8'h00, 1'b0);
		put_word(16'd64);
		// max points, long repeat with trailing repeat count consumed
		put_byte(8'h00, 1'b1); put_byte(8'h10, 1'b0);
		for (int i = 0; i < 8; i++) put_byte(8'h00, 1'b0);
		for (int i = 0; i < 15; i++) put_word(16'(i * 4));
		put_word(16'd63);
		put_word(16'd0);
		put_byte(8'h39, 1'b0); put_byte(8'hFF, 1'b0);
		wait (arst_n);
		// random glyphs, mostly small
		for (int g = 0; g < 4; g++) begin
			wait (pending_bytes.size() < 50);
			@(posedge clk);
			case ($urandom_range(0, 9))
				0: begin
					put_byte(8'($urandom), 1'b1);
					for (int i = 0; i < $urandom_range(0, 12); i++)
						put_byte(8'($urandom), 1'($urandom_range(0, 15) == 0));
				end
				1: put_glyph($urandom_range(1, 3), $urandom_range(3, 12), 1);
				2: begin
					nc = $urandom_range(1, 16);
					put_glyph(nc, $urandom_range(nc, 24), 0);
				end
				default: begin
					np = $urandom_range(1, 8);
					put_glyph($urandom_range(1, np < 3 ? np : 3), np, 0);
				end
			endcase
		end
		stim_done = 1;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		wait (pending_bytes.size() == 0 && !in_valid);
		wait (expected_points.size() == 0);
		repeat (500) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("** truetype_glyph_outline_decoder: PASSED **");
		end else begin
			$display("** truetype_glyph_outline_decoder: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
